// File: rtl/arnold_cat_map_scrambler_assert.svh
// Assertion macros used by the cat map scrambler top level.
`ifndef ARNOLD_CAT_MAP_SCRAMBLER_ASSERT_SVH
`define ARNOLD_CAT_MAP_SCRAMBLER_ASSERT_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define ACM_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define ACM_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/acm_pkg.sv
// Types and constants of the cat map scrambler.
package acm_pkg;

   typedef struct packed {
      logic [7:0] row;
      logic [7:0] col;
      logic       bit_value;
   } acm_req_type;

   typedef struct packed {
      logic [7:0] dest_row;
      logic [7:0] dest_col;
      logic       bit_out;
      logic       out_of_range;
   } acm_rsp_type;

   // Side data that rides along with the coordinates through the rounds.
   typedef struct packed {
      logic [7:0] row;
      logic [7:0] col;
      logic       bit_value;
      logic       flag;
   } acm_tag_type;

   typedef enum logic [2:0] {
      COEF_IDLE,
      COEF_START,
      COEF_DIV_A,
      COEF_DIV_B,
      COEF_DIV_D,
      COEF_DIV_M
   } acm_coef_state_type;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 9;

   localparam logic [CSR_IDX_W-1:0] CSR_DIRECTION = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MUL_A     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MUL_B     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SIDE_LEN  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ROUNDS    = 3'd4;

   localparam logic [5:0] RESET_MUL_A    = 6'd5;
   localparam logic [5:0] RESET_MUL_B    = 6'd7;
   localparam logic [8:0] RESET_SIDE_LEN = 9'd200;
   localparam logic [3:0] RESET_ROUNDS   = 4'd3;

endpackage

// File: rtl/arnold_cat_map_scrambler.sv
// Top level of the generalized Arnold cat map scrambler.
//
// req_ channel: one beat per watermark bit, carrying its row, column and value.
// rsp_ channel: one beat per request, in order, with the landing row/column,
//   the bit, and out_of_range when row or column is not below the side length
//   clamped to 2..MAX_SIDE (coordinates then come back unchanged).
// csr_ channel: register writes (direction, mul_a, mul_b, side_len, rounds);
//   csr_ready is always high.
// The pipeline has one entry stage, three stages per round
//   (products, Barrett quotient, remainder fix-up) and one output register.
//   Rounds past the programmed count pass the coordinates through.
// Throughput is one beat per cycle while neither the coefficient unit nor rsp_stall holds it.
// After reset and after every register write the coefficient unit reduces
//   a, b, a*b+1 mod n and forms floor(2^K/n) with one divider step a cycle;
//   req_stall is high while it works.
// When rsp_stall is high with a beat waiting, the whole pipeline holds and
//   req_stall follows; nothing is dropped or repeated.
module arnold_cat_map_scrambler #(
   parameter int MAX_SIDE   = 256,
   parameter int MAX_ROUNDS = 15
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  acm_pkg::acm_req_type                req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output acm_pkg::acm_rsp_type                rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [acm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [acm_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import acm_pkg::*;

   localparam int CW = $clog2(MAX_SIDE);
   localparam int NW = $clog2(MAX_SIDE + 1);
   localparam int KW = 2 * CW + 1;
   localparam int RW = $clog2(MAX_ROUNDS + 1);
   localparam int EW = (RW > 4) ? RW : 4;

   // Register file.
   logic       direction_ff;
   logic [5:0] mul_a_ff, mul_b_ff;
   logic [8:0] side_len_ff;
   logic [3:0] rounds_ff;
   logic       csr_write;

   // Coefficients.
   logic          coef_busy;
   logic [NW-1:0] side_n;
   logic [KW-1:0] recip;
   logic [CW-1:0] coef_a, coef_b, coef_d, coef_neg_a, coef_neg_b;
   logic          coef_ok;

   logic          en;
   logic          req_take;
   logic [EW-1:0] rounds_eff;

   // Entry stage.
   logic          s0_valid_ff;
   logic [CW-1:0] s0_i_ff, s0_j_ff;
   acm_tag_type   s0_tag_ff;
   logic          in_range;

   // Round chain, index k feeds round k.
   logic          ch_valid [0:MAX_ROUNDS];
   logic [CW-1:0] ch_i     [0:MAX_ROUNDS];
   logic [CW-1:0] ch_j     [0:MAX_ROUNDS];
   acm_tag_type   ch_tag   [0:MAX_ROUNDS];

   // Output register.
   logic          rsp_valid_ff;
   acm_rsp_type   rsp_data_ff;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= 1'b0;
         mul_a_ff     <= RESET_MUL_A;
         mul_b_ff     <= RESET_MUL_B;
         side_len_ff  <= RESET_SIDE_LEN;
         rounds_ff    <= RESET_ROUNDS;
      end else if (csr_write) begin
         case (csr_index)
            CSR_DIRECTION: direction_ff <= csr_wdata[0];
            CSR_MUL_A:     mul_a_ff     <= csr_wdata[5:0];
            CSR_MUL_B:     mul_b_ff     <= csr_wdata[5:0];
            CSR_SIDE_LEN:  side_len_ff  <= csr_wdata[8:0];
            CSR_ROUNDS:    rounds_ff    <= csr_wdata[3:0];
            default: begin
               // drop writes beyond the register list
            end
         endcase
      end
   end

   // Redo the coefficients after any write.
   acm_coef #(
      .MAX_SIDE (MAX_SIDE)
   ) u_coef (
      .clock      (clock),
      .reset      (reset),
      .restart    (csr_write),
      .mul_a      (mul_a_ff),
      .mul_b      (mul_b_ff),
      .side_len   (side_len_ff),
      .busy       (coef_busy),
      .side_n     (side_n),
      .recip      (recip),
      .coef_a     (coef_a),
      .coef_b     (coef_b),
      .coef_d     (coef_d),
      .coef_neg_a (coef_neg_a),
      .coef_neg_b (coef_neg_b)
   );

   assign rounds_eff = (EW'(rounds_ff) > EW'(MAX_ROUNDS)) ? EW'(MAX_ROUNDS) : EW'(rounds_ff);

   // Advance everything unless a result waits on a stalled receiver.
   assign en        = !rsp_valid_ff || !rsp_stall;
   assign req_stall = coef_busy || !en;
   assign req_take  = req_valid && !req_stall;

   assign in_range = (16'(req_data.row) < 16'(side_n)) && (16'(req_data.col) < 16'(side_n));

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (en) begin
         s0_valid_ff <= req_take;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_i_ff             <= CW'(req_data.row);
         s0_j_ff             <= CW'(req_data.col);
         s0_tag_ff.row       <= req_data.row;
         s0_tag_ff.col       <= req_data.col;
         s0_tag_ff.bit_value <= req_data.bit_value;
         s0_tag_ff.flag      <= !in_range;
      end
   end

   assign ch_valid[0] = s0_valid_ff;
   assign ch_i[0]     = s0_i_ff;
   assign ch_j[0]     = s0_j_ff;
   assign ch_tag[0]   = s0_tag_ff;

   for (genvar k = 0; k < MAX_ROUNDS; k++) begin : g_round
      logic apply;

      // Skip the round for flagged beats and past the programmed count.
      assign apply = !ch_tag[k].flag && (EW'(k) < rounds_eff);

      acm_round #(
         .MAX_SIDE (MAX_SIDE)
      ) u_round (
         .clock      (clock),
         .reset      (reset),
         .en         (en),
         .direction  (direction_ff),
         .side_n     (side_n),
         .recip      (recip),
         .coef_a     (coef_a),
         .coef_b     (coef_b),
         .coef_d     (coef_d),
         .coef_neg_a (coef_neg_a),
         .coef_neg_b (coef_neg_b),
         .in_valid   (ch_valid[k]),
         .in_apply   (apply),
         .in_i       (ch_i[k]),
         .in_j       (ch_j[k]),
         .in_tag     (ch_tag[k]),
         .out_valid  (ch_valid[k+1]),
         .out_i      (ch_i[k+1]),
         .out_j      (ch_j[k+1]),
         .out_tag    (ch_tag[k+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= ch_valid[MAX_ROUNDS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff.dest_row     <= ch_tag[MAX_ROUNDS].flag ? ch_tag[MAX_ROUNDS].row
                                                             : 8'(ch_i[MAX_ROUNDS]);
         rsp_data_ff.dest_col     <= ch_tag[MAX_ROUNDS].flag ? ch_tag[MAX_ROUNDS].col
                                                             : 8'(ch_j[MAX_ROUNDS]);
         rsp_data_ff.bit_out      <= ch_tag[MAX_ROUNDS].bit_value;
         rsp_data_ff.out_of_range <= ch_tag[MAX_ROUNDS].flag;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign coef_ok = (NW'(coef_a) < side_n) && (NW'(coef_b) < side_n)
                    && (NW'(coef_d) < side_n);

`include "arnold_cat_map_scrambler_assert.svh"

   // A register write must send the coefficient unit back to work.
   `ACM_ASSERT_NEXT(a_write_restarts_coef, csr_write, coef_busy, "coef unit not restarted")
   // Reduced coefficients stay below the modulus once settled.
   `ACM_ASSERT_SAME(a_coef_reduced, !coef_busy, coef_ok, "coefficient not reduced")
   // A held result must also hold the input side.
   `ACM_ASSERT_SAME(a_stall_backs_up, rsp_valid && rsp_stall, req_stall, "input taken while output held")

endmodule

// File: rtl/acm_coef.sv
// Coefficient unit: reduces the matrix entries mod n and forms the Barrett reciprocal.
module acm_coef #(
   parameter int MAX_SIDE = 256,
   localparam int CW = $clog2(MAX_SIDE),
   localparam int NW = $clog2(MAX_SIDE + 1),
   localparam int KW = 2 * CW + 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          restart,
   input  logic [5:0]    mul_a,
   input  logic [5:0]    mul_b,
   input  logic [8:0]    side_len,
   output logic          busy,
   output logic [NW-1:0] side_n,
   output logic [KW-1:0] recip,
   output logic [CW-1:0] coef_a,
   output logic [CW-1:0] coef_b,
   output logic [CW-1:0] coef_d,
   output logic [CW-1:0] coef_neg_a,
   output logic [CW-1:0] coef_neg_b
);
   import acm_pkg::*;

   localparam int DW   = KW + 1;
   localparam int CNTW = $clog2(DW);

   acm_coef_state_type state_ff, state_in;

   logic [NW-1:0]   n_ff;
   logic [DW-1:0]   dvd_ff;
   logic [NW-1:0]   rem_ff;
   logic [DW-1:0]   quo_ff;
   logic [CNTW-1:0] cnt_ff;
   logic [KW-1:0]   recip_ff;
   logic [CW-1:0]   a_ff, b_ff, d_ff, neg_a_ff, neg_b_ff;

   logic [NW-1:0]   n_clamp;
   logic [NW:0]     rem_sh;
   logic            ge;
   logic [NW:0]     rem_nx;
   logic [DW-1:0]   quo_nx;
   logic            last_step;
   logic [2*CW-1:0] prod_ab;

   always_comb begin
      if (side_len < 9'd2) begin
         n_clamp = NW'(2);
      end else if (32'(side_len) > MAX_SIDE) begin
         n_clamp = NW'(MAX_SIDE);
      end else begin
         n_clamp = NW'(side_len);
      end
   end

   // One restoring division step per cycle.
   assign rem_sh    = {rem_ff, dvd_ff[DW-1]};
   assign ge        = rem_sh >= {1'b0, n_ff};
   assign rem_nx    = ge ? rem_sh - {1'b0, n_ff} : rem_sh;
   assign quo_nx    = {quo_ff[DW-2:0], ge};
   assign last_step = cnt_ff == CNTW'(DW - 1);
   assign prod_ab   = a_ff * rem_nx[CW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= COEF_START;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         COEF_IDLE:  state_in = COEF_IDLE;
         COEF_START: state_in = COEF_DIV_A;
         COEF_DIV_A: if (last_step) state_in = COEF_DIV_B;
         COEF_DIV_B: if (last_step) state_in = COEF_DIV_D;
         COEF_DIV_D: if (last_step) state_in = COEF_DIV_M;
         COEF_DIV_M: if (last_step) state_in = COEF_IDLE;
         default:    state_in = COEF_START;
      endcase
      if (restart) begin
         state_in = COEF_START;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         COEF_START: begin
            n_ff   <= n_clamp;
            dvd_ff <= DW'(mul_a);
            rem_ff <= '0;
            cnt_ff <= '0;
         end
         COEF_DIV_A, COEF_DIV_B, COEF_DIV_D, COEF_DIV_M: begin
            dvd_ff <= dvd_ff << 1;
            rem_ff <= rem_nx[NW-1:0];
            quo_ff <= quo_nx;
            cnt_ff <= cnt_ff + CNTW'(1);
            if (last_step) begin
               rem_ff <= '0;
               cnt_ff <= '0;
               case (state_ff)
                  COEF_DIV_A: begin
                     a_ff   <= rem_nx[CW-1:0];
                     dvd_ff <= DW'(mul_b);
                  end
                  COEF_DIV_B: begin
                     b_ff   <= rem_nx[CW-1:0];
                     dvd_ff <= DW'(prod_ab) + DW'(1);
                  end
                  COEF_DIV_D: begin
                     d_ff     <= rem_nx[CW-1:0];
                     neg_a_ff <= (a_ff == '0) ? '0 : CW'(n_ff - NW'(a_ff));
                     neg_b_ff <= (b_ff == '0) ? '0 : CW'(n_ff - NW'(b_ff));
                     dvd_ff   <= DW'(1) << KW;
                  end
                  default: begin
                     recip_ff <= quo_nx[KW-1:0];
                  end
               endcase
            end
         end
         default: begin
         end
      endcase
   end

   assign busy       = state_ff != COEF_IDLE;
   assign side_n     = n_ff;
   assign recip      = recip_ff;
   assign coef_a     = a_ff;
   assign coef_b     = b_ff;
   assign coef_d     = d_ff;
   assign coef_neg_a = neg_a_ff;
   assign coef_neg_b = neg_b_ff;

endmodule

// File: rtl/acm_round.sv
// One round of the cat map: products, Barrett quotient, remainder fix-up.
module acm_round #(
   parameter int MAX_SIDE = 256,
   localparam int CW = $clog2(MAX_SIDE),
   localparam int NW = $clog2(MAX_SIDE + 1),
   localparam int KW = 2 * CW + 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                direction,
   input  logic [NW-1:0]       side_n,
   input  logic [KW-1:0]       recip,
   input  logic [CW-1:0]       coef_a,
   input  logic [CW-1:0]       coef_b,
   input  logic [CW-1:0]       coef_d,
   input  logic [CW-1:0]       coef_neg_a,
   input  logic [CW-1:0]       coef_neg_b,
   input  logic                in_valid,
   input  logic                in_apply,
   input  logic [CW-1:0]       in_i,
   input  logic [CW-1:0]       in_j,
   input  acm_pkg::acm_tag_type in_tag,
   output logic                out_valid,
   output logic [CW-1:0]       out_i,
   output logic [CW-1:0]       out_j,
   output acm_pkg::acm_tag_type out_tag
);
   import acm_pkg::*;

   localparam int PW = 2 * CW;

   logic [PW-1:0]   p_xi, p_xj, p_yi, p_yj;
   logic [KW-1:0]   vx, vy;

   logic            s1_valid_ff, s1_apply_ff;
   logic [CW-1:0]   s1_i_ff, s1_j_ff;
   acm_tag_type     s1_tag_ff;
   logic [KW-1:0]   s1_vx_ff, s1_vy_ff;

   logic [2*KW-1:0] px, py;

   logic            s2_valid_ff, s2_apply_ff;
   logic [CW-1:0]   s2_i_ff, s2_j_ff;
   acm_tag_type     s2_tag_ff;
   logic [KW-1:0]   s2_vx_ff, s2_vy_ff, s2_qx_ff, s2_qy_ff;

   logic [KW+NW-1:0] qnx, qny;
   logic [KW-1:0]    rx, ry, rx_fix, ry_fix;

   logic            s3_valid_ff;
   logic [CW-1:0]   s3_i_ff, s3_j_ff;
   acm_tag_type     s3_tag_ff;

   // Forward: x = i + b*j, y = a*i + d*j. Inverse: x = d*i + (-b)*j, y = j + (-a)*i.
   always_comb begin
      if (direction == 1'b0) begin
         p_xi = PW'(in_i);
         p_xj = coef_b * in_j;
         p_yi = coef_a * in_i;
         p_yj = coef_d * in_j;
      end else begin
         p_xi = coef_d * in_i;
         p_xj = coef_neg_b * in_j;
         p_yi = coef_neg_a * in_i;
         p_yj = PW'(in_j);
      end
   end

   assign vx = KW'(p_xi) + KW'(p_xj);
   assign vy = KW'(p_yi) + KW'(p_yj);

   // Quotient estimate, at most one short of the true quotient.
   assign px = s1_vx_ff * recip;
   assign py = s1_vy_ff * recip;

   assign qnx    = s2_qx_ff * side_n;
   assign qny    = s2_qy_ff * side_n;
   assign rx     = s2_vx_ff - qnx[KW-1:0];
   assign ry     = s2_vy_ff - qny[KW-1:0];
   assign rx_fix = (rx >= KW'(side_n)) ? rx - KW'(side_n) : rx;
   assign ry_fix = (ry >= KW'(side_n)) ? ry - KW'(side_n) : ry;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_apply_ff <= in_apply;
         s1_i_ff     <= in_i;
         s1_j_ff     <= in_j;
         s1_tag_ff   <= in_tag;
         s1_vx_ff    <= vx;
         s1_vy_ff    <= vy;

         s2_apply_ff <= s1_apply_ff;
         s2_i_ff     <= s1_i_ff;
         s2_j_ff     <= s1_j_ff;
         s2_tag_ff   <= s1_tag_ff;
         s2_vx_ff    <= s1_vx_ff;
         s2_vy_ff    <= s1_vy_ff;
         s2_qx_ff    <= px[2*KW-1:KW];
         s2_qy_ff    <= py[2*KW-1:KW];

         // Skipped rounds hold the coordinates as they came in.
         s3_i_ff     <= s2_apply_ff ? CW'(rx_fix) : s2_i_ff;
         s3_j_ff     <= s2_apply_ff ? CW'(ry_fix) : s2_j_ff;
         s3_tag_ff   <= s2_tag_ff;
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_i     = s3_i_ff;
   assign out_j     = s3_j_ff;
   assign out_tag   = s3_tag_ff;

endmodule
